// ===== rtl/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and codes for the timeout timer table.
// ----------------------------------------------------------------------------
package mtt_pkg;

   localparam int TYPE_W     = 2;
   localparam int INDEX_W    = 4;
   localparam int DURATION_W = 16;
   localparam int STATUS_W   = 2;
   localparam int ALARM_W    = 16;
   localparam int TIME_W     = 32;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_START = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_STOP  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RUNNING   = 2'd2;

   // five minutes
   localparam logic [ALARM_W-1:0] CAP_RESET = 16'd300;

   // one table entry as it comes back from the deadline memory
   typedef struct packed {
      logic               valid;
      logic               running;
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0]  deadline;
   } scan_entry_type;

   // what one scan pass concluded
   typedef struct packed {
      logic               expired_valid;
      logic [INDEX_W-1:0] expired_index;
      logic [ALARM_W-1:0] next_alarm;
   } scan_result_type;

endpackage

// ===== rtl/mtt_scan_acc.sv =====
// ----------------------------------------------------------------------------
// mtt_scan_acc
// Walks the table entries one per cycle and keeps the most overdue timer
// and the two smallest remaining times, then forms the result of the pass.
// ----------------------------------------------------------------------------
module mtt_scan_acc
   import mtt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic [ALARM_W-1:0]    cap,
   input  logic [TIME_W-1:0]     now_time,
   input  logic                  is_tick,
   input  scan_entry_type        entry,
   output scan_result_type       result
);

   logic               found_ff, found_in;
   logic [TIME_W-2:0]  most_ff, most_in;
   logic [INDEX_W-1:0] exp_idx_ff, exp_idx_in;
   logic signed [TIME_W-1:0] min1_ff, min1_in;
   logic signed [TIME_W-1:0] min2_ff, min2_in;
   logic [INDEX_W-1:0] min1_idx_ff, min1_idx_in;
   logic               hit_ff, hit_in;
   logic [1:0]         run_cnt_ff, run_cnt_in;

   logic [TIME_W-1:0]        over;
   logic signed [TIME_W-1:0] left;
   logic signed [TIME_W-1:0] best;
   logic                     any_left;

   assign over = now_time - entry.deadline;
   assign left = signed'(entry.deadline - now_time);

   always_comb begin
      found_in    = found_ff;
      most_in     = most_ff;
      exp_idx_in  = exp_idx_ff;
      min1_in     = min1_ff;
      min2_in     = min2_ff;
      min1_idx_in = min1_idx_ff;
      hit_in      = hit_ff;
      run_cnt_in  = run_cnt_ff;
      if (clear) begin
         found_in    = 1'b0;
         most_in     = '0;
         exp_idx_in  = '0;
         min1_in     = signed'(TIME_W'(cap));
         min2_in     = signed'(TIME_W'(cap));
         min1_idx_in = '0;
         hit_in      = 1'b0;
         run_cnt_in  = 2'd0;
      end else if (entry.valid && entry.running) begin
         if (run_cnt_ff != 2'd2) begin
            run_cnt_in = run_cnt_ff + 2'd1;
         end
         // overdue by a non-negative amount; ties go to the later index
         if (is_tick && !over[TIME_W-1] && over[TIME_W-2:0] >= most_ff) begin
            found_in   = 1'b1;
            most_in    = over[TIME_W-2:0];
            exp_idx_in = entry.index;
         end
         if (left <= min1_ff) begin
            min2_in     = min1_ff;
            min1_in     = left;
            min1_idx_in = entry.index;
            hit_in      = 1'b1;
         end else if (left < min2_ff) begin
            min2_in = left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         hit_ff     <= 1'b0;
         run_cnt_ff <= 2'd0;
      end else begin
         found_ff   <= found_in;
         hit_ff     <= hit_in;
         run_cnt_ff <= run_cnt_in;
      end
      most_ff     <= most_in;
      exp_idx_ff  <= exp_idx_in;
      min1_ff     <= min1_in;
      min2_ff     <= min2_in;
      min1_idx_ff <= min1_idx_in;
   end

   // the expired timer drops out of the next alarm
   assign best = (found_ff && hit_ff && exp_idx_ff == min1_idx_ff) ? min2_ff : min1_ff;
   assign any_left = (run_cnt_ff == 2'd2) || (run_cnt_ff == 2'd1 && !found_ff);

   always_comb begin
      result.expired_valid = found_ff;
      result.expired_index = found_ff ? exp_idx_ff : '0;
      if (!any_left) begin
         result.next_alarm = '0;
      end else if (best <= 0) begin
         result.next_alarm = ALARM_W'(1);
      end else begin
         result.next_alarm = best[ALARM_W-1:0];
      end
   end

endmodule

// ===== rtl/multi_timeout_timer_table.sv =====
// ----------------------------------------------------------------------------
// multi_timeout_timer_table
// Table of one-shot timeout timers on a shared seconds clock.
// ----------------------------------------------------------------------------
// Each item (start, stop or one-second tick) goes through the same steps:
// it is accepted and updates the table, the deadline memory is read out
// entry by entry over its single read port, the last read returns, and the
// result is loaded once the output register is free. No new item is taken
// until the result is loaded. A result waits in the output register while
// the next item is accepted. Deadlines live in a memory; the running flags
// are flip-flops cleared by reset. The alarm cap register is written through
// the csr port, which is always ready.
module multi_timeout_timer_table
   import mtt_pkg::*;
#(
   parameter int TIMER_COUNT = 9
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TYPE_W-1:0]     req_type,
   input  logic [INDEX_W-1:0]    req_timer_index,
   input  logic [DURATION_W-1:0] req_duration_seconds,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_expired_valid,
   output logic [INDEX_W-1:0]    rsp_expired_index,
   output logic [ALARM_W-1:0]    rsp_next_alarm_seconds,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ALARM_W-1:0]    csr_alarm_cap_seconds
);

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int CNT_W = $clog2(TIMER_COUNT + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [TIMER_COUNT-1:0] running_ff, running_in;
   logic [ALARM_W-1:0]     cap_ff, cap_in;
   logic [TYPE_W-1:0]      type_ff, type_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [CNT_W-1:0]       addr_ff, addr_in;

   logic [TIME_W-1:0]      deadline_mem [TIMER_COUNT];
   logic [TIME_W-1:0]      rd_deadline_ff;
   logic                   rd_valid_ff;
   logic                   rd_run_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_last_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_expired_valid_ff;
   logic [INDEX_W-1:0]     rsp_expired_index_ff;
   logic [ALARM_W-1:0]     rsp_next_alarm_ff;

   logic                   req_accept;
   logic                   idx_ok;
   logic [IDX_W-1:0]       req_idx;
   logic                   wr_en;
   logic                   issue;
   logic                   out_free;
   logic                   load;
   logic                   acc_clear;
   scan_entry_type         entry;
   scan_result_type        summary;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign idx_ok  = (req_timer_index < INDEX_W'(TIMER_COUNT));
   assign req_idx = req_timer_index[IDX_W-1:0];
   assign wr_en   = req_accept && req_type == REQ_START && idx_ok && !running_ff[req_idx];
   assign issue   = (state_ff == ST_SCAN) && (addr_ff < CNT_W'(TIMER_COUNT));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == ST_DONE) && out_free;
   assign acc_clear = req_accept;

   always_comb begin
      state_in   = state_ff;
      time_in    = time_ff;
      running_in = running_ff;
      cap_in     = (csr_valid && csr_ready) ? csr_alarm_cap_seconds : cap_ff;
      type_in    = type_ff;
      status_in  = status_ff;
      addr_in    = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               type_in   = req_type;
               status_in = STATUS_OK;
               addr_in   = '0;
               state_in  = ST_SCAN;
               if (req_type == REQ_START || req_type == REQ_STOP) begin
                  if (!idx_ok) begin
                     status_in = STATUS_BAD_INDEX;
                  end else if (req_type == REQ_STOP) begin
                     running_in[req_idx] = 1'b0;
                  end else if (running_ff[req_idx]) begin
                     status_in = STATUS_RUNNING;
                  end else begin
                     running_in[req_idx] = 1'b1;
                  end
               end else if (req_type == REQ_TICK) begin
                  time_in = time_ff + TIME_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (rd_valid_ff && rd_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               if (summary.expired_valid) begin
                  running_in[summary.expired_index[IDX_W-1:0]] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         running_ff   <= '0;
         cap_ff       <= CAP_RESET;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         running_ff   <= running_in;
         cap_ff       <= cap_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff   <= type_in;
      status_ff <= status_in;
   end

   // deadline memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         deadline_mem[req_idx] <= time_ff + TIME_W'(req_duration_seconds);
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_deadline_ff <= deadline_mem[addr_ff[IDX_W-1:0]];
         rd_run_ff      <= running_ff[addr_ff[IDX_W-1:0]];
         rd_idx_ff      <= addr_ff[IDX_W-1:0];
         rd_last_ff     <= (addr_ff == CNT_W'(TIMER_COUNT - 1));
      end
   end

   always_comb begin
      entry.valid    = rd_valid_ff;
      entry.running  = rd_run_ff;
      entry.index    = INDEX_W'(rd_idx_ff);
      entry.deadline = rd_deadline_ff;
   end

   mtt_scan_acc u_scan_acc (
      .clock    (clock),
      .reset    (reset),
      .clear    (acc_clear),
      .cap      (cap_ff),
      .now_time (time_ff),
      .is_tick  (type_ff == REQ_TICK),
      .entry    (entry),
      .result   (summary)
   );

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff        <= status_ff;
         rsp_expired_valid_ff <= summary.expired_valid;
         rsp_expired_index_ff <= summary.expired_index;
         rsp_next_alarm_ff    <= summary.next_alarm;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_expired_valid      = rsp_expired_valid_ff;
   assign rsp_expired_index      = rsp_expired_index_ff;
   assign rsp_next_alarm_seconds = rsp_next_alarm_ff;

   // an item enters only when the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == ST_IDLE)
      else $error("item accepted while a scan is in progress");

   // the read address never runs more than one past the last table entry
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> addr_ff <= CNT_W'(TIMER_COUNT))
      else $error("scan address past the table");

   // a reported expiry leaves that timer disarmed
   assert property (@(posedge clock) disable iff (reset)
      load && summary.expired_valid |=>
         !running_ff[$past(summary.expired_index[IDX_W-1:0])])
      else $error("expired timer still running");

   // next alarm is zero exactly when no timer is left running
   assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_next_alarm_seconds == '0) == (running_ff == '0))
      else $error("next alarm disagrees with running timers");

   // no expiry is reported without a tick
   assert property (@(posedge clock) disable iff (reset)
      load && summary.expired_valid |-> type_ff == REQ_TICK && status_ff == STATUS_OK)
      else $error("expiry reported outside a tick");

endmodule
